@@ hw/rtl/world_to_screen_projection_assert.svh @@
// Assertion macros for the world-to-screen projection block.
// Included by the top level; no other dependencies.
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH

// same-cycle implication, off during reset
`define WTSP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wtsp check failed");

// next-cycle implication, live during reset
`define WTSP_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wtsp check failed");

`endif

@@ hw/rtl/wtsp_pkg.sv @@
// Shared types and constants for the world-to-screen projection block.
// No dependencies.
package wtsp_pkg;

  localparam int ROW_W  = 32;  // one packed matrix coefficient
  localparam int CFG_W  = 64;  // configuration data width
  localparam int SIZE_W = 13;  // viewport size field

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd1080;

  typedef enum logic [2:0] {
    REG_DEPTH_XY  = 3'd0,
    REG_DEPTH_ZW  = 3'd1,
    REG_RIGHT_XY  = 3'd2,
    REG_RIGHT_ZW  = 3'd3,
    REG_UP_XY     = 3'd4,
    REG_UP_ZW     = 3'd5,
    REG_WIDTH     = 3'd6,
    REG_HEIGHT    = 3'd7
  } reg_index_t;

endpackage

@@ hw/rtl/wtsp_div.sv @@
// Pipelined two-lane unsigned restoring divider, one quotient bit per stage.
// Standalone; used by world_to_screen_projection.
module wtsp_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 33,
  parameter int TAG_W = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  input  logic [NUM_W-1:0] src_num_x,
  input  logic [DEN_W-1:0] src_den_x,
  input  logic [NUM_W-1:0] src_num_y,
  input  logic [DEN_W-1:0] src_den_y,
  input  logic [TAG_W-1:0] src_tag,
  output logic             res_valid,
  output logic [NUM_W-1:0] res_quo_x,
  output logic [NUM_W-1:0] res_quo_y,
  output logic [TAG_W-1:0] res_tag
);

  logic             vld   [NUM_W];
  logic [TAG_W-1:0] tag   [NUM_W];
  logic [NUM_W-1:0] num_x [NUM_W];
  logic [NUM_W-1:0] num_y [NUM_W];
  logic [NUM_W-1:0] quo_x [NUM_W];
  logic [NUM_W-1:0] quo_y [NUM_W];
  logic [DEN_W-1:0] rem_x [NUM_W];
  logic [DEN_W-1:0] rem_y [NUM_W];
  logic [DEN_W-1:0] den_x [NUM_W];
  logic [DEN_W-1:0] den_y [NUM_W];

  // returns {quotient bit, new remainder}
  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                              input logic nbit,
                                              input logic [DEN_W-1:0] den);
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {1'b1, diff[DEN_W-1:0]};
    end
    return {1'b0, trial[DEN_W-1:0]};
  endfunction

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             p_vld;
    logic [TAG_W-1:0] p_tag;
    logic [NUM_W-1:0] p_num_x, p_num_y, p_quo_x, p_quo_y;
    logic [DEN_W-1:0] p_rem_x, p_rem_y, p_den_x, p_den_y;
    logic [DEN_W:0]   st_x, st_y;

    if (k == 0) begin : g_first
      assign p_vld   = src_valid;
      assign p_tag   = src_tag;
      assign p_num_x = src_num_x;
      assign p_num_y = src_num_y;
      assign p_quo_x = '0;
      assign p_quo_y = '0;
      assign p_rem_x = '0;
      assign p_rem_y = '0;
      assign p_den_x = src_den_x;
      assign p_den_y = src_den_y;
    end else begin : g_next
      assign p_vld   = vld[k-1];
      assign p_tag   = tag[k-1];
      assign p_num_x = num_x[k-1];
      assign p_num_y = num_y[k-1];
      assign p_quo_x = quo_x[k-1];
      assign p_quo_y = quo_y[k-1];
      assign p_rem_x = rem_x[k-1];
      assign p_rem_y = rem_y[k-1];
      assign p_den_x = den_x[k-1];
      assign p_den_y = den_y[k-1];
    end

    assign st_x = div_step(p_rem_x, p_num_x[NUM_W-1], p_den_x);
    assign st_y = div_step(p_rem_y, p_num_y[NUM_W-1], p_den_y);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= p_vld;
      end
      tag[k]   <= p_tag;
      num_x[k] <= p_num_x << 1;
      num_y[k] <= p_num_y << 1;
      quo_x[k] <= {p_quo_x[NUM_W-2:0], st_x[DEN_W]};
      quo_y[k] <= {p_quo_y[NUM_W-2:0], st_y[DEN_W]};
      rem_x[k] <= st_x[DEN_W-1:0];
      rem_y[k] <= st_y[DEN_W-1:0];
      den_x[k] <= p_den_x;
      den_y[k] <= p_den_y;
    end
  end

  assign res_valid = vld[NUM_W-1];
  assign res_quo_x = quo_x[NUM_W-1];
  assign res_quo_y = quo_y[NUM_W-1];
  assign res_tag   = tag[NUM_W-1];

endmodule

@@ hw/rtl/world_to_screen_projection.sv @@
// Throughput: one point per cycle; busy is low except during reset.
// Depth is set by two bit-per-stage dividers, each COORD_WIDTH+14 stages.
// Synchronous reset clears valid bits and config (rows 0, 1920x1080).
// done strobes for one cycle per result; the receiver cannot stall.
module world_to_screen_projection #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       point_x,
  input  logic signed [COORD_WIDTH-1:0]       point_y,
  input  logic signed [COORD_WIDTH-1:0]       point_z,
  input  logic                                wr_en,
  input  logic [2:0]                          wr_index,
  input  logic [wtsp_pkg::CFG_W-1:0]          wr_data,
  output logic                                done,
  output logic                                visible,
  output logic signed [COORD_WIDTH-1:0]       screen_frac_x,
  output logic signed [COORD_WIDTH-1:0]       screen_frac_y,
  output logic signed [COORD_WIDTH-1:0]       view_depth
);
  import wtsp_pkg::*;

  `include "world_to_screen_projection_assert.svh"

  localparam int CW    = COORD_WIDTH;
  localparam int PW    = CW + ROW_W;
  localparam int SW    = PW - FRAC_BITS;
  localparam int EW    = (SW > 63 ? SW : 63) + 3;
  localparam int NW    = CW + SIZE_W + 1;
  localparam int DW_A  = CW + 1;
  localparam int DW_B  = SIZE_W + 1;
  localparam int TW    = CW + 3;
  localparam int CBW   = SIZE_W + 1 + CW - FRAC_BITS;
  localparam int VIS_MIN = ((1 << FRAC_BITS) + 999) / 1000;

  localparam logic signed [CW-1:0] QMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] QMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [EW-1:0] PLIM = EW'(64'sd1 <<< 61);
  localparam logic signed [EW-1:0] NLIM = -PLIM;

  // configuration
  logic [CFG_W-1:0]  row_cfg [6];
  logic [SIZE_W-1:0] view_width, view_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) row_cfg[i] <= '0;
      view_width  <= WIDTH_RESET;
      view_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_DEPTH_XY: row_cfg[0] <= wr_data;
        REG_DEPTH_ZW: row_cfg[1] <= wr_data;
        REG_RIGHT_XY: row_cfg[2] <= wr_data;
        REG_RIGHT_ZW: row_cfg[3] <= wr_data;
        REG_UP_XY:    row_cfg[4] <= wr_data;
        REG_UP_ZW:    row_cfg[5] <= wr_data;
        REG_WIDTH:    view_width  <= wr_data[SIZE_W-1:0];
        REG_HEIGHT:   view_height <= wr_data[SIZE_W-1:0];
        default:      ;
      endcase
    end
  end

  assign busy = rst;

  // zero size counts as one
  logic [SIZE_W:0] wv, hv;
  assign wv = (view_width  == '0) ? (SIZE_W+1)'(1) : {1'b0, view_width};
  assign hv = (view_height == '0) ? (SIZE_W+1)'(1) : {1'b0, view_height};

  function automatic logic signed [ROW_W-1:0] coef(input int r, input int j);
    logic [CFG_W-1:0] xy, zw;
    xy = row_cfg[2*r];
    zw = row_cfg[2*r+1];
    unique case (j)
      0:       return xy[ROW_W-1:0];
      1:       return xy[CFG_W-1:ROW_W];
      2:       return zw[ROW_W-1:0];
      default: return zw[CFG_W-1:ROW_W];
    endcase
  endfunction

  function automatic logic signed [EW-1:0] shift_clamp(input logic signed [PW-1:0] p);
    logic signed [EW-1:0] t;
    t = EW'(p >>> FRAC_BITS);
    if (t > PLIM) t = PLIM;
    else if (t < NLIM) t = NLIM;
    return t;
  endfunction

  function automatic logic signed [CW-1:0] sat_q(input logic signed [EW-1:0] v);
    if (v > EW'(QMAX)) return QMAX;
    if (v < EW'(QMIN)) return QMIN;
    return v[CW-1:0];
  endfunction

  // signed result from sign and magnitude, saturated
  function automatic logic signed [CW-1:0] sat_mag(input logic neg,
                                                    input logic [NW-1:0] mag);
    if (!neg) begin
      if (mag > NW'(QMAX)) return QMAX;
      return mag[CW-1:0];
    end
    if (mag > NW'(QMAX) + NW'(1)) return QMIN;
    return -mag[CW-1:0];
  endfunction

  // stage 1: products
  logic signed [CW-1:0] pt [3];
  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  logic                 s1_valid;
  logic signed [PW-1:0] prod [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        prod[r][j] <= pt[j] * coef(r, j);
      end
    end
  end

  // stage 2: sum and saturate; row 0 depth, 1 right, 2 up
  logic                 s2_valid;
  logic signed [CW-1:0] s2_dot [3];
  logic signed [EW-1:0] acc [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = shift_clamp(prod[r][0]) + shift_clamp(prod[r][1])
             + shift_clamp(prod[r][2]) + EW'(coef(r, 3));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    for (int r = 0; r < 3; r++) s2_dot[r] <= sat_q(acc[r]);
  end

  // stage 3: numerators v*S + depth, denominator 2*depth
  logic                 vis3;
  logic signed [NW:0]   nx3, ny3;
  logic [NW:0]          ax3, ay3;

  assign vis3 = s2_dot[0] >= CW'(VIS_MIN);
  assign nx3  = s2_dot[1] * $signed(wv) + s2_dot[0];
  assign ny3  = s2_dot[2] * $signed(hv) + s2_dot[0];
  assign ax3  = nx3[NW] ? -nx3 : nx3;
  assign ay3  = ny3[NW] ? -ny3 : ny3;

  logic             s3_valid;
  logic [NW-1:0]    s3_num_x, s3_num_y;
  logic [DW_A-1:0]  s3_den;
  logic [TW-1:0]    s3_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_num_x <= ax3[NW-1:0];
    s3_num_y <= ay3[NW-1:0];
    s3_den   <= vis3 ? {s2_dot[0], 1'b0} : DW_A'(1);
    s3_tag   <= {vis3, nx3[NW], ny3[NW], s2_dot[0]};
  end

  logic          da_valid;
  logic [NW-1:0] da_quo_x, da_quo_y;
  logic [TW-1:0] da_tag;

  wtsp_div #(.NUM_W(NW), .DEN_W(DW_A), .TAG_W(TW)) u_div_offset (
    .clk       (clk),
    .rst       (rst),
    .src_valid (s3_valid),
    .src_num_x (s3_num_x),
    .src_den_x (s3_den),
    .src_num_y (s3_num_y),
    .src_den_y (s3_den),
    .src_tag   (s3_tag),
    .res_valid (da_valid),
    .res_quo_x (da_quo_x),
    .res_quo_y (da_quo_y),
    .res_tag   (da_tag)
  );

  // stage 4: q = S +/- 2*offset, clamped where the result saturates anyway
  logic signed [NW:0]   ox4, oy4;
  logic signed [NW+2:0] qx4, qy4;
  logic [NW+2:0]        aqx4, aqy4;
  logic [CBW-1:0]       limx4, limy4, mqx4, mqy4;

  always_comb begin
    ox4   = da_tag[TW-2] ? -$signed({1'b0, da_quo_x}) : $signed({1'b0, da_quo_x});
    oy4   = da_tag[TW-3] ? -$signed({1'b0, da_quo_y}) : $signed({1'b0, da_quo_y});
    qx4   = $signed((NW+3)'(wv)) + ((NW+3)'(ox4) <<< 1);
    qy4   = $signed((NW+3)'(hv)) - ((NW+3)'(oy4) <<< 1);
    aqx4  = qx4[NW+2] ? -qx4 : qx4;
    aqy4  = qy4[NW+2] ? -qy4 : qy4;
    limx4 = CBW'(wv) << (CW - FRAC_BITS + 1);
    limy4 = CBW'(hv) << (CW - FRAC_BITS + 1);
    mqx4  = (aqx4 > (NW+3)'(limx4)) ? limx4 : aqx4[CBW-1:0];
    mqy4  = (aqy4 > (NW+3)'(limy4)) ? limy4 : aqy4[CBW-1:0];
  end

  logic            s4_valid;
  logic [NW-1:0]   s4_num_x, s4_num_y;
  logic [DW_B-1:0] s4_den_x, s4_den_y;
  logic [TW-1:0]   s4_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= da_valid;
    end
    s4_num_x <= {mqx4, {FRAC_BITS{1'b0}}};
    s4_num_y <= {mqy4, {FRAC_BITS{1'b0}}};
    s4_den_x <= {wv[SIZE_W-1:0], 1'b0};
    s4_den_y <= {hv[SIZE_W-1:0], 1'b0};
    s4_tag   <= {da_tag[TW-1], qx4[NW+2], qy4[NW+2], da_tag[CW-1:0]};
  end

  logic          db_valid;
  logic [NW-1:0] db_quo_x, db_quo_y;
  logic [TW-1:0] db_tag;

  wtsp_div #(.NUM_W(NW), .DEN_W(DW_B), .TAG_W(TW)) u_div_screen (
    .clk       (clk),
    .rst       (rst),
    .src_valid (s4_valid),
    .src_num_x (s4_num_x),
    .src_den_x (s4_den_x),
    .src_num_y (s4_num_y),
    .src_den_y (s4_den_y),
    .src_tag   (s4_tag),
    .res_valid (db_valid),
    .res_quo_x (db_quo_x),
    .res_quo_y (db_quo_y),
    .res_tag   (db_tag)
  );

  // stage 5: sign, saturate, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= db_valid;
    end
    visible       <= db_tag[TW-1];
    screen_frac_x <= db_tag[TW-1] ? sat_mag(db_tag[TW-2], db_quo_x) : '0;
    screen_frac_y <= db_tag[TW-1] ? sat_mag(db_tag[TW-3], db_quo_y) : '0;
    view_depth    <= db_tag[CW-1:0];
  end

  `WTSP_ASSERT_IMP(a_hidden_zero, clk, rst, done && !visible, screen_frac_x == '0 && screen_frac_y == '0)
  `WTSP_ASSERT_IMP(a_visible_depth, clk, rst, done && visible, view_depth >= CW'(VIS_MIN))
  `WTSP_ASSERT_NEXT(a_reset_quiet, clk, rst, !done)

endmodule
